### rtl/segx_pkg.sv
// ----------------------------------------------------------------------------
// segx_pkg
// types and widths shared by the segment intersection pipeline
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int CoordWidth = 16;
  localparam int FracBits   = 8;
  localparam int DiffWidth  = CoordWidth + 1;        // endpoint differences
  localparam int ProdWidth  = 2 * DiffWidth;         // cross product terms
  localparam int NumWidth   = ProdWidth + 1;         // signed den / nt / nu
  localparam int MagWidth   = NumWidth - 1;          // |den|, nt when in range
  localparam int DMagWidth  = CoordWidth;            // |dx|, |dy|
  localparam int QuoWidth   = DMagWidth;             // quotient bits, one per cell
  localparam int RemWidth   = MagWidth + DMagWidth + 2;
  localparam int DvsWidth   = MagWidth + QuoWidth + 1;

  typedef struct packed {
    logic                         ok;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [CoordWidth-1:0] ax1;
    logic signed [CoordWidth-1:0] ay1;
    logic [RemWidth-1:0]          rem_x;
    logic [RemWidth-1:0]          rem_y;
    logic [DvsWidth-1:0]          dvs;
    logic [QuoWidth-1:0]          q_x;
    logic [QuoWidth-1:0]          q_y;
  } cell_t;

endpackage

### rtl/segx_front.sv
// ----------------------------------------------------------------------------
// segx_front
// cross products, sign fix and range test, numerators for the divider cells
// ----------------------------------------------------------------------------
module segx_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_x1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_y1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_x2_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_y2_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_x1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_y1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_x2_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_y2_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output segx_pkg::cell_t                        data_o
);

  localparam int W  = segx_pkg::CoordWidth;
  localparam int DW = segx_pkg::DiffWidth;
  localparam int PW = segx_pkg::ProdWidth;
  localparam int NW = segx_pkg::NumWidth;
  localparam int UW = segx_pkg::MagWidth;
  localparam int MW = segx_pkg::DMagWidth;
  localparam int RW = segx_pkg::RemWidth;
  localparam int VW = segx_pkg::DvsWidth;
  localparam int QW = segx_pkg::QuoWidth;

  // stage a: differences and products
  logic signed [DW-1:0] dxa, dya, dxb, dyb, ex, ey;
  logic                 va_q, rdy_a;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DW-1:0] dxa_q, dya_q;
  logic signed [W-1:0]  ax1_a_q, ay1_a_q;

  // stage b: sign fix and span test
  logic                 vb_q, rdy_b;
  logic signed [NW-1:0] den, nt, nu, nt_f, nu_f, den_f;
  logic                 ok_b;
  logic [UW-1:0]        den_q, nt_q;
  logic                 ok_q, negx_q, negy_q;
  logic [MW-1:0]        dxm_q, dym_q;
  logic signed [W-1:0]  ax1_b_q, ay1_b_q;

  // stage c: scaled numerators
  logic                 vc_q, rdy_c;
  logic [UW+MW-1:0]     px, py;
  segx_pkg::cell_t      cell_d, cell_q;

  assign dxa = DW'(a_x2_i) - DW'(a_x1_i);
  assign dya = DW'(a_y2_i) - DW'(a_y1_i);
  assign dxb = DW'(b_x2_i) - DW'(b_x1_i);
  assign dyb = DW'(b_y2_i) - DW'(b_y1_i);
  assign ex  = DW'(b_x1_i) - DW'(a_x1_i);
  assign ey  = DW'(b_y1_i) - DW'(a_y1_i);

  assign rdy_c   = ~vc_q | ready_i;
  assign rdy_b   = ~vb_q | rdy_c;
  assign rdy_a   = ~va_q | rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      p0_q    <= PW'(dxa) * PW'(dyb);
      p1_q    <= PW'(dya) * PW'(dxb);
      p2_q    <= PW'(ex) * PW'(dyb);
      p3_q    <= PW'(ey) * PW'(dxb);
      p4_q    <= PW'(ex) * PW'(dya);
      p5_q    <= PW'(ey) * PW'(dxa);
      dxa_q   <= dxa;
      dya_q   <= dya;
      ax1_a_q <= a_x1_i;
      ay1_a_q <= a_y1_i;
    end
  end

  assign den = NW'(p0_q) - NW'(p1_q);
  assign nt  = NW'(p2_q) - NW'(p3_q);
  assign nu  = NW'(p4_q) - NW'(p5_q);

  always_comb begin
    // make the denominator positive, numerators follow
    den_f = den[NW-1] ? -den : den;
    nt_f  = den[NW-1] ? -nt  : nt;
    nu_f  = den[NW-1] ? -nu  : nu;
    ok_b  = (den != '0) && !nt_f[NW-1] && !nu_f[NW-1] &&
            (nt_f <= den_f) && (nu_f <= den_f);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      den_q   <= den_f[UW-1:0];
      nt_q    <= nt_f[UW-1:0];
      ok_q    <= ok_b;
      negx_q  <= dxa_q[DW-1];
      negy_q  <= dya_q[DW-1];
      dxm_q   <= dxa_q[DW-1] ? MW'(-dxa_q) : MW'(dxa_q);
      dym_q   <= dya_q[DW-1] ? MW'(-dya_q) : MW'(dya_q);
      ax1_b_q <= ax1_a_q;
      ay1_b_q <= ay1_a_q;
    end
  end

  assign px = (UW+MW)'(nt_q) * (UW+MW)'(dxm_q);
  assign py = (UW+MW)'(nt_q) * (UW+MW)'(dym_q);

  always_comb begin
    cell_d       = '0;
    cell_d.ok    = ok_q;
    cell_d.neg_x = negx_q;
    cell_d.neg_y = negy_q;
    cell_d.ax1   = ax1_b_q;
    cell_d.ay1   = ay1_b_q;
    // round to nearest: (2p + den) / (2 den)
    cell_d.rem_x = (RW'(px) << 1) + RW'(den_q);
    cell_d.rem_y = (RW'(py) << 1) + RW'(den_q);
    // divisor 2 den, aligned to the top quotient bit and one more shift
    cell_d.dvs   = VW'(den_q) << (QW + 1);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) cell_q <= cell_d;
  end

  assign valid_o = vc_q;
  assign data_o  = cell_q;

endmodule

### rtl/segx_cell.sv
// ----------------------------------------------------------------------------
// segx_cell
// one restoring divide step for both x and y lanes, one quotient bit each
// ----------------------------------------------------------------------------
module segx_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  segx_pkg::cell_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output segx_pkg::cell_t data_o
);

  localparam int RW = segx_pkg::RemWidth;
  localparam int QW = segx_pkg::QuoWidth;

  logic            valid_q, rdy;
  logic [RW-1:0]   dv;
  logic            ge_x, ge_y;
  segx_pkg::cell_t data_d, data_q;

  assign rdy     = ~valid_q | ready_i;
  assign ready_o = rdy;

  always_comb begin
    // divisor arrives pre-shifted by one, so this cell tests the bit it halves to
    data_d       = data_i;
    dv           = RW'(data_i.dvs >> 1);
    ge_x         = data_i.rem_x >= dv;
    ge_y         = data_i.rem_y >= dv;
    data_d.dvs   = data_i.dvs >> 1;
    data_d.rem_x = ge_x ? data_i.rem_x - dv : data_i.rem_x;
    data_d.rem_y = ge_y ? data_i.rem_y - dv : data_i.rem_y;
    data_d.q_x   = {data_i.q_x[QW-2:0], ge_x};
    data_d.q_y   = {data_i.q_y[QW-2:0], ge_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/segment_intersection_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_top
// crossing point of two line segments, pipelined with a divider cell chain
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  in        in_valid_i/in_ready_o, a_*_i, b_*_i     word in
//  out       out_valid_o/out_ready_i, cross_*_o,     word out
//            found_o
//
//  accepts one word per cycle while the output is not stalled; pipeline of
//  3 front stages, 16 divide cells at one quotient bit each, 1 output register
//  every stage holds its word under stall and takes a new one once empty
//  reset clears only the valid bits of the stages
// ----------------------------------------------------------------------------
module segment_intersection_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_x1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_y1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_x2_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] a_y2_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_x1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_y1_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_x2_i,
  input  logic signed [segx_pkg::CoordWidth-1:0] b_y2_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [segx_pkg::CoordWidth-1:0] cross_x_o,
  output logic signed [segx_pkg::CoordWidth-1:0] cross_y_o,
  output logic                                   found_o
);

  localparam int W  = segx_pkg::CoordWidth;
  localparam int QW = segx_pkg::QuoWidth;

  logic            v   [QW+1];
  logic            r   [QW+1];
  segx_pkg::cell_t d   [QW+1];
  logic            out_valid_q, out_rdy;
  logic signed [W+1:0] sx, sy;
  logic signed [W-1:0] cx_q, cy_q;
  logic            found_q;

  segx_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .a_x1_i  (a_x1_i),
    .a_y1_i  (a_y1_i),
    .a_x2_i  (a_x2_i),
    .a_y2_i  (a_y2_i),
    .b_x1_i  (b_x1_i),
    .b_y1_i  (b_y1_i),
    .b_x2_i  (b_x2_i),
    .b_y2_i  (b_y2_i),
    .valid_o (v[0]),
    .ready_i (r[0]),
    .data_o  (d[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    segx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (r[k]),
      .data_i  (d[k]),
      .valid_o (v[k+1]),
      .ready_i (r[k+1]),
      .data_o  (d[k+1])
    );
  end

  assign out_rdy = ~out_valid_q | out_ready_i;
  assign r[QW]   = out_rdy;

  always_comb begin
    sx = (W+2)'(d[QW].ax1) + (d[QW].neg_x ? -(W+2)'(d[QW].q_x) : (W+2)'(d[QW].q_x));
    sy = (W+2)'(d[QW].ay1) + (d[QW].neg_y ? -(W+2)'(d[QW].q_y) : (W+2)'(d[QW].q_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      found_q <= d[QW].ok;
      cx_q    <= d[QW].ok ? sx[W-1:0] : '0;
      cy_q    <= d[QW].ok ? sy[W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;
  assign found_o     = found_q;

endmodule

### rtl/segx_checker.sv
// ----------------------------------------------------------------------------
// segx_checker
// port level checks for the segment intersection block
// ----------------------------------------------------------------------------
module segx_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [segx_pkg::CoordWidth-1:0] cross_x_o,
  input logic signed [segx_pkg::CoordWidth-1:0] cross_y_o,
  input logic                                   found_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cross_x_o) &&
    $stable(cross_y_o) && $stable(found_o))
    else $error("result changed while stalled");

  // no crossing means zero coordinates
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> cross_x_o == '0 && cross_y_o == '0)
    else $error("nonzero point without crossing");

  // input stalls only behind a waiting result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with free output");

endmodule

bind segment_intersection_top segx_checker u_segx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cross_x_o   (cross_x_o),
  .cross_y_o   (cross_y_o),
  .found_o     (found_o)
);
